### hw/rtl/world_to_screen_projection_top_macros.svh
// Assertion helpers, clocked on clk and idle while arst_n is low
`ifndef WORLD_TO_SCREEN_PROJECTION_TOP_MACROS_SVH
`define WORLD_TO_SCREEN_PROJECTION_TOP_MACROS_SVH

// consequent holds in the same cycle
`define WSP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the cycle after the antecedent
`define WSP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/wsp_pkg.sv
package wsp_pkg;

	localparam int FRAC_BITS = 16;

	localparam int PROD_W  = 64;
	localparam int SH_W    = PROD_W - FRAC_BITS;
	localparam int ACC_W   = SH_W + 2;
	localparam int NUM_W   = 50;
	localparam int DIVN_W  = NUM_W + FRAC_BITS;
	localparam int HI_W    = DIVN_W - 32;
	localparam int CMP_W   = (HI_W > 32) ? HI_W : 32;
	localparam int STEP_W  = 4;
	localparam int N_STEPS = 12;
	localparam int CNT_W   = 5;

	localparam logic signed [31:0] ONE_FX  = 32'(64'd1 << FRAC_BITS);
	localparam logic signed [31:0] NEAR_FX =
		32'(((64'd1 << FRAC_BITS) + 64'd5000) / 64'd10000);
	localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
	localparam logic [15:0] DIAG_MASK = 16'b1000_0100_0010_0001;

	localparam logic MODE_LOAD    = 1'b0;
	localparam logic MODE_PROJECT = 1'b1;

	localparam int CFG_IDX_W = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW_WIDTH  = 4'd0,
		REG_WINDOW_HEIGHT = 4'd1
	} cfg_reg_t;

	typedef struct packed {
		logic              mode;
		logic [3:0]        entry_index;
		logic signed [31:0] entry_value;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
	} in_item_t;

	typedef struct packed {
		logic              visible;
		logic signed [31:0] screen_x;
		logic signed [31:0] screen_y;
	} out_item_t;

	typedef struct packed {
		logic              wr_entry;
		logic              latch_pt;
		logic              mul_en;
		logic [STEP_W-1:0] step;
		logic              num_en;
		logic              div_start;
		logic              out_load;
	} wsp_cmd_t;

	typedef struct packed {
		logic div_busy;
	} wsp_sts_t;

	function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		hi = ACC_W'(S32_MAX);
		lo = ACC_W'(S32_MIN);
		if (v > hi) begin
			return S32_MAX;
		end else if (v < lo) begin
			return S32_MIN;
		end
		return v[31:0];
	endfunction

endpackage

### hw/rtl/wsp_if.sv
interface wsp_in_if import wsp_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface wsp_out_if import wsp_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface wsp_cfg_if import wsp_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [15:0]          data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

### hw/rtl/world_to_screen_projection_top.sv
// channel   dir  transfer payload
// in_ch     in   mode, entry_index, entry_value, point_x, point_y, point_z
// out_ch    out  visible, screen_x, screen_y
// cfg_ch    in   index, data (window_width, window_height)
//
// Load item: no result. Project item: no new input transfer until its result is
// loaded; twelve products through one 32x32 multiplier plus a drain state, two
// setup states, then two 32-step restoring dividers run side by side (with a done
// check), one state to load the output register.
// arst_n clears control, window registers and the matrix to identity.
// A finished result sits in the output register; a new item is taken while it
// waits, and the next result stalls only until that register frees up.
`include "world_to_screen_projection_top_macros.svh"

module world_to_screen_projection_top import wsp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	wsp_in_if.sink      in_ch,
	wsp_out_if.source   out_ch,
	wsp_cfg_if.sink     cfg_ch
);

	wsp_cmd_t cmd;
	wsp_sts_t sts;
	logic     cfg_wr;

	assign cfg_ch.ready = 1'b1;
	assign cfg_wr       = cfg_ch.valid && cfg_ch.ready;

	wsp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_mode   (in_ch.data.mode),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	wsp_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_ch.data),
		.cfg_wr    (cfg_wr),
		.cfg_index (cfg_ch.index),
		.cfg_data  (cfg_ch.data),
		.cmd       (cmd),
		.sts       (sts),
		.out_item  (out_ch.data)
	);

	`WSP_ASSERT_NOW(a_ready_not_busy, in_ch.ready, !sts.div_busy, "input ready while dividing")
	`WSP_ASSERT_NOW(a_load_free, cmd.out_load, !out_ch.valid || out_ch.ready, "result overwritten")
	`WSP_ASSERT_NEXT(a_div_runs, cmd.div_start, sts.div_busy, "divider did not start")
	`WSP_ASSERT_NOW(a_hidden_zero, out_ch.valid && !out_ch.data.visible, out_ch.data.screen_x == 32'sd0 && out_ch.data.screen_y == 32'sd0, "hidden point has coordinates")

endmodule

### hw/rtl/wsp_div.sv
module wsp_div import wsp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [DIVN_W-1:0]  num,
	input  logic [31:0]        den,
	input  logic               neg,
	output logic               busy,
	output logic signed [31:0] result
);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [31:0]      rem_q;
	logic [31:0]      quo_q;
	logic [31:0]      den_q;
	logic             neg_q;
	logic             ovf_q;

	logic [CMP_W-1:0] hi_ext;
	logic [32:0]      trial;
	logic [32:0]      diff;
	logic             ge;
	logic [32:0]      mag_up;

	assign hi_ext = CMP_W'(num[DIVN_W-1:32]);
	assign trial  = {rem_q, quo_q[31]};
	assign diff   = trial - {1'b0, den_q};
	assign ge     = trial >= {1'b0, den_q};
	assign mag_up = {1'b0, quo_q} + 33'(rem_q != 32'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(31)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= hi_ext[31:0];
			quo_q <= num[31:0];
			den_q <= den;
			neg_q <= neg;
			ovf_q <= hi_ext >= CMP_W'(den);
		end else if (busy_q) begin
			rem_q <= ge ? diff[31:0] : trial[31:0];
			quo_q <= {quo_q[30:0], ge};
		end
	end

	// floor for negative quotients, then clamp to 32 bits
	always_comb begin
		if (!neg_q) begin
			result = (ovf_q || quo_q[31]) ? S32_MAX : quo_q;
		end else if (ovf_q || mag_up > 33'h1_0000_0000 >> 1) begin
			result = S32_MIN;
		end else begin
			result = 32'(-mag_up);
		end
	end

	assign busy = busy_q;

endmodule

### hw/rtl/wsp_dp.sv
module wsp_dp import wsp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  in_item_t             in_item,
	input  logic                 cfg_wr,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data,
	input  wsp_cmd_t             cmd,
	output wsp_sts_t             sts,
	output out_item_t            out_item
);

	logic signed [31:0] mat_q [16];
	logic [15:0]        win_w_q;
	logic [15:0]        win_h_q;

	logic signed [31:0] px_q;
	logic signed [31:0] py_q;
	logic signed [31:0] pz_q;

	logic signed [PROD_W-1:0] prod_s1;
	logic [STEP_W-1:0]        step_s1;
	logic                     mv_s1;

	logic signed [ACC_W-1:0] acc_q;
	logic signed [31:0]      cx_q;
	logic signed [31:0]      cy_q;
	logic signed [31:0]      cw_q;

	logic signed [NUM_W-1:0] nx_q;
	logic signed [NUM_W-1:0] ny_q;
	logic                    vis_q;
	out_item_t               out_q;

	logic [1:0]              row;
	logic [3:0]              idx;
	logic signed [31:0]      m_rd;
	logic signed [31:0]      coord;
	logic signed [SH_W-1:0]  sh;
	logic signed [ACC_W-1:0] sh_ext;
	logic signed [ACC_W-1:0] acc_next;
	logic signed [32:0]      sum_x;
	logic signed [32:0]      sum_y;
	logic signed [16:0]      ww_ext;
	logic signed [16:0]      wh_ext;
	logic [NUM_W-1:0]        nx_mag;
	logic [NUM_W-1:0]        ny_mag;
	logic [31:0]             den;
	logic                    busy_x;
	logic                    busy_y;
	logic signed [31:0]      qx;
	logic signed [31:0]      qy;

	// step = row_sel*4 + col; col 3 is the translation term
	assign row    = (cmd.step[3:2] == 2'd2) ? 2'd3 : cmd.step[3:2];
	assign idx    = {cmd.step[1:0], row};
	assign m_rd   = mat_q[idx];

	always_comb begin
		case (cmd.step[1:0])
			2'd0:    coord = px_q;
			2'd1:    coord = py_q;
			2'd2:    coord = pz_q;
			default: coord = ONE_FX;
		endcase
	end

	assign sh       = prod_s1[PROD_W-1:FRAC_BITS];
	assign sh_ext   = ACC_W'(sh);
	assign acc_next = (step_s1[1:0] == 2'd0) ? sh_ext : acc_q + sh_ext;

	assign sum_x  = 33'(cx_q) + 33'(cw_q);
	assign sum_y  = 33'(cw_q) - 33'(cy_q);
	assign ww_ext = $signed({1'b0, win_w_q});
	assign wh_ext = $signed({1'b0, win_h_q});
	assign nx_mag = nx_q[NUM_W-1] ? NUM_W'(-nx_q) : NUM_W'(nx_q);
	assign ny_mag = ny_q[NUM_W-1] ? NUM_W'(-ny_q) : NUM_W'(ny_q);
	assign den    = {cw_q[30:0], 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) begin
				mat_q[i] <= DIAG_MASK[i] ? ONE_FX : 32'sd0;
			end
			win_w_q <= '0;
			win_h_q <= '0;
			mv_s1   <= 1'b0;
		end else begin
			if (cmd.wr_entry) begin
				mat_q[in_item.entry_index] <= in_item.entry_value;
			end
			if (cfg_wr) begin
				case (cfg_index)
					REG_WINDOW_WIDTH:  win_w_q <= cfg_data;
					REG_WINDOW_HEIGHT: win_h_q <= cfg_data;
					default: ;
				endcase
			end
			mv_s1 <= cmd.mul_en;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_pt) begin
			px_q <= in_item.point_x;
			py_q <= in_item.point_y;
			pz_q <= in_item.point_z;
		end
		prod_s1 <= m_rd * coord;
		step_s1 <= cmd.step;
		if (mv_s1) begin
			acc_q <= acc_next;
			if (step_s1[1:0] == 2'd3) begin
				case (step_s1[3:2])
					2'd0:    cx_q <= sat32(acc_next);
					2'd1:    cy_q <= sat32(acc_next);
					default: cw_q <= sat32(acc_next);
				endcase
			end
		end
		if (cmd.num_en) begin
			nx_q  <= sum_x * ww_ext;
			ny_q  <= sum_y * wh_ext;
			vis_q <= cw_q > NEAR_FX;
		end
		if (cmd.out_load) begin
			out_q.visible  <= vis_q;
			out_q.screen_x <= vis_q ? qx : 32'sd0;
			out_q.screen_y <= vis_q ? qy : 32'sd0;
		end
	end

	wsp_div u_div_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    ({nx_mag, {FRAC_BITS{1'b0}}}),
		.den    (den),
		.neg    (nx_q[NUM_W-1]),
		.busy   (busy_x),
		.result (qx)
	);

	wsp_div u_div_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    ({ny_mag, {FRAC_BITS{1'b0}}}),
		.den    (den),
		.neg    (ny_q[NUM_W-1]),
		.busy   (busy_y),
		.result (qy)
	);

	assign sts.div_busy = busy_x | busy_y;
	assign out_item     = out_q;

endmodule

### hw/rtl/wsp_ctrl.sv
module wsp_ctrl import wsp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_mode,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output wsp_cmd_t cmd,
	input  wsp_sts_t sts
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_DRAIN,
		S_NUM,
		S_DIVGO,
		S_DIV,
		S_WB
	} state_t;

	state_t            state_q;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	logic              accept;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd           = '0;
		cmd.wr_entry  = accept && (in_mode == MODE_LOAD);
		cmd.latch_pt  = accept && (in_mode == MODE_PROJECT);
		cmd.mul_en    = (state_q == S_MUL);
		cmd.step      = step_q;
		cmd.num_en    = (state_q == S_NUM);
		cmd.div_start = (state_q == S_DIVGO);
		cmd.out_load  = (state_q == S_WB) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd.latch_pt) begin
						step_q  <= '0;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					if (step_q == STEP_W'(N_STEPS - 1)) begin
						state_q <= S_DRAIN;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				S_DRAIN: state_q <= S_NUM;
				S_NUM:   state_q <= S_DIVGO;
				S_DIVGO: state_q <= S_DIV;
				S_DIV: begin
					if (!sts.div_busy) begin
						state_q <= S_WB;
					end
				end
				S_WB: begin
					if (cmd.out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule
